>>> sv/assert_macros.svh
// Assertion macros shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a property holds in the cycle after a trigger.
`define TCW_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

>>> sv/tcw_pkg.sv
// Types and constants of the text console writer.
package tcw_pkg;

	// Widths of screen row and column sums (frame origin plus caret or counter).
	localparam int unsigned ROW_SUM_W = 6;
	localparam int unsigned COL_SUM_W = 8;

	// Item kinds.
	localparam logic [1:0] KIND_PUT  = 2'd0;
	localparam logic [1:0] KIND_SET  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Control characters.
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] CH_NUL       = 8'd0;

	// Register indexes.
	localparam logic [2:0] REG_WINDOW_TOP    = 3'd0;
	localparam logic [2:0] REG_WINDOW_LEFT   = 3'd1;
	localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd2;
	localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
	localparam logic [2:0] REG_TEXT_COLOR    = 3'd4;
	localparam logic [2:0] REG_PAPER_COLOR   = 3'd5;
	localparam logic [2:0] REG_CURSOR_SHOWN  = 3'd6;

	// Register reset values.
	localparam logic [4:0] RST_WINDOW_HEIGHT = 5'd25;
	localparam logic [6:0] RST_WINDOW_WIDTH  = 7'd80;
	localparam logic [3:0] RST_TEXT_COLOR    = 4'd2;
	localparam logic [3:0] RST_PAPER_COLOR   = 4'd0;

	typedef struct packed {
		logic [3:0] back;
		logic [3:0] fore;
		logic [7:0] ch;
	} cell_t;

	localparam cell_t RST_CELL = '{back: RST_PAPER_COLOR, fore: RST_TEXT_COLOR, ch: CH_NUL};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_code;
		logic [4:0] row_sel;
		logic [6:0] col_sel;
	} item_t;

	typedef struct packed {
		logic [10:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [3:0]  cell_fore;
		logic [3:0]  cell_back;
	} result_t;

endpackage

>>> sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/text_console_writer_core.sv
// Text console writer: screen store, caret, frame window and upward scroll.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+----------------------------
//  item     | item_valid / item_ready         | item (item_t)
//  result   | result_valid / result_ready     | result (result_t)
//  config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// Set caret and hidden kinds pass ST_DECODE then ST_DONE; put character adds ST_PUT,
// plain newline ST_NEWLINE, read ST_READ and ST_RDATA, a character that wraps both
// ST_PUT and ST_NEWLINE. A scroll uses one shared address unit and one RAM port pair
// for each cell copy, as a read step then a write step, and then fills the bottom row.
// After reset a clearing pass writes all SCREEN_ROWS*SCREEN_COLS cells, one a
// cycle, with item_ready low; config writes are taken meanwhile.
// A result waiting on result_ready stalls only the final step of the next item.
`include "assert_macros.svh"

module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int unsigned SCREEN_COLS = 80,
	parameter int unsigned SCREEN_ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned LINW  =
		$clog2(((1 << ROW_SUM_W) - 1) * SCREEN_COLS + (1 << COL_SUM_W));

	typedef enum logic [10:0] {
		ST_CLEAR   = 11'b00000000001,
		ST_IDLE    = 11'b00000000010,
		ST_DECODE  = 11'b00000000100,
		ST_PUT     = 11'b00000001000,
		ST_NEWLINE = 11'b00000010000,
		ST_SCR_RD  = 11'b00000100000,
		ST_SCR_WR  = 11'b00001000000,
		ST_FILL    = 11'b00010000000,
		ST_READ    = 11'b00100000000,
		ST_RDATA   = 11'b01000000000,
		ST_DONE    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [4:0] window_top_q;
	logic [6:0] window_left_q;
	logic [4:0] window_height_q;
	logic [6:0] window_width_q;
	logic [3:0] text_color_q;
	logic [3:0] paper_color_q;
	logic       cursor_shown_q;

	logic [4:0]    caret_line_q;
	logic [6:0]    caret_column_q;
	logic [4:0]    srow_q;
	logic [6:0]    scol_q;
	logic [AW-1:0] clr_cnt_q;
	item_t         item_q;
	cell_t         cell_q;
	logic          src_ok_q;
	logic          result_valid_q;
	result_t       result_q;

	logic [4:0]           eff_h;
	logic [6:0]           eff_w;
	logic [ROW_SUM_W-1:0] row_u;
	logic [COL_SUM_W-1:0] col_u;
	logic [LINW-1:0]      lin;
	logic                 in_bounds;
	logic                 cfg_wr;
	logic [6:0]           col_inc;
	logic [5:0]           line_inc;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	cell_t                ram_wdata;
	cell_t                ram_rdata;

	assign eff_h    = (window_height_q == 5'd0) ? 5'd1 : window_height_q;
	assign eff_w    = (window_width_q == 7'd0) ? 7'd1 : window_width_q;
	assign col_inc  = caret_column_q + 7'd1;
	assign line_inc = 6'(caret_line_q) + 6'd1;

	// Shared address unit: screen row and column to linear offset plus bounds.
	always_comb begin
		row_u = ROW_SUM_W'(window_top_q) + ROW_SUM_W'(caret_line_q);
		col_u = COL_SUM_W'(window_left_q) + COL_SUM_W'(caret_column_q);
		case (state_q)
			ST_READ: begin
				row_u = ROW_SUM_W'(item_q.row_sel);
				col_u = COL_SUM_W'(item_q.col_sel);
			end
			ST_SCR_RD: begin
				row_u = ROW_SUM_W'(window_top_q) + ROW_SUM_W'(srow_q);
				col_u = COL_SUM_W'(window_left_q) + COL_SUM_W'(scol_q);
			end
			ST_SCR_WR: begin
				row_u = ROW_SUM_W'(window_top_q) + ROW_SUM_W'(srow_q) - ROW_SUM_W'(1);
				col_u = COL_SUM_W'(window_left_q) + COL_SUM_W'(scol_q);
			end
			ST_FILL: begin
				row_u = ROW_SUM_W'(window_top_q) + ROW_SUM_W'(eff_h) - ROW_SUM_W'(1);
				col_u = COL_SUM_W'(window_left_q) + COL_SUM_W'(scol_q);
			end
			default: begin
			end
		endcase
	end

	assign lin       = LINW'(row_u) * LINW'(SCREEN_COLS) + LINW'(col_u);
	assign in_bounds = (32'(row_u) < SCREEN_ROWS) && (32'(col_u) < SCREEN_COLS);

	// Memory write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(lin);
		ram_wdata = RST_CELL;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
			end
			ST_PUT: begin
				ram_we = in_bounds;
				if (item_q.char_code == CH_BACKSPACE) begin
					ram_wdata = '{back: paper_color_q, fore: paper_color_q, ch: CH_SPACE};
				end else begin
					ram_wdata = '{back: paper_color_q, fore: text_color_q, ch: item_q.char_code};
				end
			end
			ST_SCR_WR: begin
				ram_we    = in_bounds;
				ram_wdata = src_ok_q ? ram_rdata : cell_t'('0);
			end
			ST_FILL: begin
				ram_we    = in_bounds;
				ram_wdata = '{back: paper_color_q, fore: text_color_q, ch: CH_NUL};
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH ($bits(cell_t)),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AW'(lin)),
		.rdata (ram_rdata)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_top_q    <= '0;
			window_left_q   <= '0;
			window_height_q <= RST_WINDOW_HEIGHT;
			window_width_q  <= RST_WINDOW_WIDTH;
			text_color_q    <= RST_TEXT_COLOR;
			paper_color_q   <= RST_PAPER_COLOR;
			cursor_shown_q  <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_WINDOW_TOP:    window_top_q    <= pwdata[4:0];
				REG_WINDOW_LEFT:   window_left_q   <= pwdata[6:0];
				REG_WINDOW_HEIGHT: window_height_q <= pwdata[4:0];
				REG_WINDOW_WIDTH:  window_width_q  <= pwdata[6:0];
				REG_TEXT_COLOR:    text_color_q    <= pwdata[3:0];
				REG_PAPER_COLOR:   paper_color_q   <= pwdata[3:0];
				REG_CURSOR_SHOWN:  cursor_shown_q  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_WINDOW_TOP:    prdata = 32'(window_top_q);
			REG_WINDOW_LEFT:   prdata = 32'(window_left_q);
			REG_WINDOW_HEIGHT: prdata = 32'(window_height_q);
			REG_WINDOW_WIDTH:  prdata = 32'(window_width_q);
			REG_TEXT_COLOR:    prdata = 32'(text_color_q);
			REG_PAPER_COLOR:   prdata = 32'(paper_color_q);
			REG_CURSOR_SHOWN:  prdata = 32'(cursor_shown_q);
			default:           prdata = '0;
		endcase
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		case (state_q)
			ST_DECODE: cell_q   <= '0;
			ST_RDATA:  cell_q   <= src_ok_q ? ram_rdata : cell_t'('0);
			ST_READ:   src_ok_q <= in_bounds;
			ST_SCR_RD: src_ok_q <= in_bounds;
			default: begin
			end
		endcase
		if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
			result_q.cursor_offset <= cursor_shown_q ? 11'(lin) : 11'(CELLS);
			result_q.cell_char     <= cell_q.ch;
			result_q.cell_fore     <= cell_q.fore;
			result_q.cell_back     <= cell_q.back;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			caret_line_q   <= '0;
			caret_column_q <= '0;
			srow_q         <= '0;
			scol_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (item_q.kind)
						KIND_PUT: begin
							case (item_q.char_code)
								CH_RETURN: begin
									caret_column_q <= '0;
									state_q        <= ST_DONE;
								end
								CH_BACKSPACE: begin
									if (caret_column_q != 7'd0) begin
										caret_column_q <= caret_column_q - 7'd1;
										state_q        <= ST_PUT;
									end else begin
										state_q <= ST_DONE;
									end
								end
								CH_NEWLINE: state_q <= ST_NEWLINE;
								default:    state_q <= ST_PUT;
							endcase
						end
						KIND_SET: begin
							caret_line_q   <= item_q.row_sel;
							caret_column_q <= item_q.col_sel;
							state_q        <= ST_DONE;
						end
						KIND_READ: state_q <= ST_READ;
						default:   state_q <= ST_DONE;
					endcase
				end
				ST_PUT: begin
					if (item_q.char_code != CH_BACKSPACE) begin
						caret_column_q <= col_inc;
						if (col_inc == 7'd0 || col_inc >= eff_w) begin
							state_q <= ST_NEWLINE;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_NEWLINE: begin
					caret_column_q <= '0;
					if (line_inc >= 6'(eff_h)) begin
						caret_line_q <= eff_h - 5'd1;
						srow_q       <= 5'd1;
						scol_q       <= '0;
						state_q      <= (eff_h == 5'd1) ? ST_FILL : ST_SCR_RD;
					end else begin
						caret_line_q <= line_inc[4:0];
						state_q      <= ST_DONE;
					end
				end
				ST_SCR_RD: state_q <= ST_SCR_WR;
				ST_SCR_WR: begin
					if (scol_q == eff_w - 7'd1) begin
						scol_q <= '0;
						if (srow_q == eff_h - 5'd1) begin
							state_q <= ST_FILL;
						end else begin
							srow_q  <= srow_q + 5'd1;
							state_q <= ST_SCR_RD;
						end
					end else begin
						scol_q  <= scol_q + 7'd1;
						state_q <= ST_SCR_RD;
					end
				end
				ST_FILL: begin
					if (scol_q == eff_w - 7'd1) begin
						state_q <= ST_DONE;
					end else begin
						scol_q <= scol_q + 7'd1;
					end
				end
				ST_READ:  state_q <= ST_RDATA;
				ST_RDATA: state_q <= ST_DONE;
				ST_DONE: begin
					if (!result_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TCW_ASSERT_NEXT(a_one_item_at_a_time, item_valid && item_ready, !item_ready,
		"item accepted while busy")
	`TCW_ASSERT(a_no_write_when_idle, (state_q == ST_IDLE) |-> !ram_we,
		"screen store written with no item in progress")
	`TCW_ASSERT(a_scroll_col_in_frame,
		(state_q == ST_SCR_RD || state_q == ST_SCR_WR || state_q == ST_FILL) |-> (scol_q < eff_w),
		"scroll column beyond frame width")
	`TCW_ASSERT_NEXT(a_newline_caret_in_frame, state_q == ST_NEWLINE, caret_line_q < eff_h,
		"caret line beyond frame after newline")
	`TCW_ASSERT_NEXT(a_result_after_done, state_q == ST_DONE && item_ready == 1'b0 &&
		(!result_valid_q || result_ready), result_valid_q,
		"finished item gave no result")

endmodule

>>> dv/text_console_writer_core_tb.sv
// Self-checking testbench for the text console writer: directed and random item traffic.
module text_console_writer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	text_console_writer_core #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Console mirror: screen copy, caret and register settings.
	cell_t      screen_copy [SCREEN_ROWS*SCREEN_COLS];
	int         mirror_line = 0;
	int         mirror_column = 0;
	int         win_top = 0;
	int         win_left = 0;
	int         win_h = int'(RST_WINDOW_HEIGHT);
	int         win_w = int'(RST_WINDOW_WIDTH);
	logic [3:0] text_color = RST_TEXT_COLOR;
	logic [3:0] paper_color = RST_PAPER_COLOR;
	logic       show_cursor = 1'b1;

	result_t awaited_reports [$];
	int      fail_count = 0;
	int      idle_pct = 20;
	int      stall_pct = 5;
	int      stall_left = 0;
	int      quiet_cycles = 0;
	result_t due_report;

	initial begin
		foreach (screen_copy[i])
			screen_copy[i] = RST_CELL;
	end

	function automatic int eff_height();
		return (win_h == 0) ? 1 : win_h;
	endfunction

	function automatic int eff_width();
		return (win_w == 0) ? 1 : win_w;
	endfunction

	function automatic cell_t peek_cell(input int row, input int col);
		if (row >= SCREEN_ROWS || col >= SCREEN_COLS)
			return '0;
		return screen_copy[row*SCREEN_COLS + col];
	endfunction

	function automatic void poke_cell(input int row, input int col, input cell_t v);
		if (row >= SCREEN_ROWS || col >= SCREEN_COLS)
			return;
		screen_copy[row*SCREEN_COLS + col] = v;
	endfunction

	function automatic void roll_frame_up();
		int h;
		int w;
		h = eff_height();
		w = eff_width();
		for (int r = 1; r < h; r++)
			for (int c = 0; c < w; c++)
				poke_cell(win_top + r - 1, win_left + c, peek_cell(win_top + r, win_left + c));
		for (int c = 0; c < w; c++)
			poke_cell(win_top + h - 1, win_left + c,
				'{back: paper_color, fore: text_color, ch: CH_NUL});
	endfunction

	function automatic void next_line();
		mirror_column = 0;
		if (mirror_line + 1 >= eff_height()) begin
			roll_frame_up();
			mirror_line = eff_height() - 1;
		end else begin
			mirror_line = mirror_line + 1;
		end
	endfunction

	function automatic void mirror_put(input logic [7:0] code);
		if (code == CH_RETURN) begin
			mirror_column = 0;
		end else if (code == CH_BACKSPACE) begin
			if (mirror_column > 0) begin
				mirror_column--;
				poke_cell(win_top + mirror_line, win_left + mirror_column,
					'{back: paper_color, fore: paper_color, ch: CH_SPACE});
			end
		end else if (code == CH_NEWLINE) begin
			next_line();
		end else begin
			poke_cell(win_top + mirror_line, win_left + mirror_column,
				'{back: paper_color, fore: text_color, ch: code});
			mirror_column = (mirror_column + 1) & 'h7F;
			if (mirror_column == 0 || mirror_column >= eff_width())
				next_line();
		end
	endfunction

	function automatic result_t apply_console_item(input item_t it);
		result_t rep;
		cell_t   got;
		int      off;
		got = '0;
		case (it.kind)
			KIND_PUT: mirror_put(it.char_code);
			KIND_SET: begin
				mirror_line = int'(it.row_sel);
				mirror_column = int'(it.col_sel);
			end
			KIND_READ: got = peek_cell(int'(it.row_sel), int'(it.col_sel));
			default: ;
		endcase
		if (show_cursor)
			off = (win_top + mirror_line) * SCREEN_COLS + win_left + mirror_column;
		else
			off = SCREEN_ROWS * SCREEN_COLS;
		rep.cursor_offset = off[10:0];
		rep.cell_char = got.ch;
		rep.cell_fore = got.fore;
		rep.cell_back = got.back;
		return rep;
	endfunction

	function automatic item_t make_item(input logic [1:0] kind, input logic [7:0] code,
		input logic [4:0] row, input logic [6:0] col);
		item_t it;
		it.kind = kind;
		it.char_code = code;
		it.row_sel = row;
		it.col_sel = col;
		return it;
	endfunction

	// Result side: random stall bursts and comparison against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (awaited_reports.size() == 0) begin
				$error("unexpected result transaction: %p", result);
				fail_count++;
			end else begin
				due_report = awaited_reports.pop_front();
				if (result.cursor_offset !== due_report.cursor_offset) begin
					$error("cursor_offset: expected %0d, actual %0d",
						due_report.cursor_offset, result.cursor_offset);
					fail_count++;
				end
				if (result.cell_char !== due_report.cell_char) begin
					$error("cell_char: expected %0d, actual %0d",
						due_report.cell_char, result.cell_char);
					fail_count++;
				end
				if (result.cell_fore !== due_report.cell_fore) begin
					$error("cell_fore: expected %0d, actual %0d",
						due_report.cell_fore, result.cell_fore);
					fail_count++;
				end
				if (result.cell_back !== due_report.cell_back) begin
					$error("cell_back: expected %0d, actual %0d",
						due_report.cell_back, result.cell_back);
					fail_count++;
				end
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
			stall_left = $urandom_range(0, 11);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(input item_t it);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		// Keep valid high into the next transaction; lower it only for a gap.
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		awaited_reports.push_back(apply_console_item(it));
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WINDOW_TOP:    win_top = int'(value[4:0]);
			REG_WINDOW_LEFT:   win_left = int'(value[6:0]);
			REG_WINDOW_HEIGHT: win_h = int'(value[4:0]);
			REG_WINDOW_WIDTH:  win_w = int'(value[6:0]);
			REG_TEXT_COLOR:    text_color = value[3:0];
			REG_PAPER_COLOR:   paper_color = value[3:0];
			REG_CURSOR_SHOWN:  show_cursor = value[0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input int top, input int left, input int height, input int width,
		input logic [3:0] fg, input logic [3:0] bg, input logic shown);
		wait_idle();
		write_reg(REG_WINDOW_TOP, 32'(top));
		write_reg(REG_WINDOW_LEFT, 32'(left));
		write_reg(REG_WINDOW_HEIGHT, 32'(height));
		write_reg(REG_WINDOW_WIDTH, 32'(width));
		write_reg(REG_TEXT_COLOR, 32'(fg));
		write_reg(REG_PAPER_COLOR, 32'(bg));
		write_reg(REG_CURSOR_SHOWN, 32'(shown));
	endtask

	// Mostly random character bytes, caret moves and reads inside the frame; the rest anywhere.
	task automatic run_traffic(input int count, input int newline_pct);
		item_t it;
		int    pick;
		repeat (count) begin
			it.char_code = 8'($urandom_range(0, 255));
			it.row_sel = 5'($urandom_range(0, 31));
			it.col_sel = 7'($urandom_range(0, 127));
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				it.kind = KIND_PUT;
				pick = $urandom_range(0, 99);
				if (pick < newline_pct)
					it.char_code = CH_NEWLINE;
				else if (pick < newline_pct + 5)
					it.char_code = CH_RETURN;
				else if (pick < newline_pct + 10)
					it.char_code = CH_BACKSPACE;
			end else if (pick < 70) begin
				it.kind = KIND_SET;
				if ($urandom_range(0, 4) != 0) begin
					it.row_sel = 5'($urandom_range(0, eff_height() - 1));
					it.col_sel = 7'($urandom_range(0, eff_width() - 1));
				end
			end else if (pick < 97) begin
				it.kind = KIND_READ;
				if ($urandom_range(0, 4) != 0) begin
					it.row_sel = 5'(win_top + int'($urandom_range(0, eff_height() - 1)));
					it.col_sel = 7'(win_left + int'($urandom_range(0, eff_width() - 1)));
				end
			end else begin
				it.kind = KIND_NONE;
			end
			send_item(it);
		end
	endtask

	task automatic test_reset_store();
		send_item(make_item(KIND_READ, 8'h00, 5'd0, 7'd0));
		send_item(make_item(KIND_READ, 8'hFF, 5'd24, 7'd79));
		send_item(make_item(KIND_READ, 8'h00, 5'd31, 7'd127));
		send_item(make_item(KIND_NONE, 8'hFF, 5'd31, 7'd127));
	endtask

	task automatic test_control_chars();
		set_frame(2, 3, 3, 4, 4'hF, 4'h0, 1'b1);
		send_item(make_item(KIND_SET, 8'h00, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, 8'h41, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, 8'hFF, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, CH_RETURN, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, CH_NUL, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, 8'h78, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, 8'h79, 5'd0, 7'd0));
		// Fourth column fills the frame row and wraps.
		send_item(make_item(KIND_PUT, 8'h7A, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0));
		send_item(make_item(KIND_READ, 8'h00, 5'd2, 7'd3));
		send_item(make_item(KIND_READ, 8'h00, 5'd3, 7'd4));
		// Caret far outside the frame: the write is dropped and the column wraps to zero.
		send_item(make_item(KIND_SET, 8'h00, 5'd31, 7'd127));
		send_item(make_item(KIND_PUT, 8'h71, 5'd0, 7'd0));
		send_item(make_item(KIND_READ, 8'h00, 5'd4, 7'd3));
	endtask

	task automatic test_frame_edges();
		wait_idle();
		// Junk above each register's width must be dropped; zero size acts as one.
		write_reg(REG_WINDOW_TOP, 32'hFFFF_FFF8);
		write_reg(REG_WINDOW_LEFT, 32'hFFFF_FFCF);
		write_reg(REG_WINDOW_HEIGHT, 32'hFFFF_FFE0);
		write_reg(REG_WINDOW_WIDTH, 32'hFFFF_FF80);
		write_reg(REG_TEXT_COLOR, 32'hFFFF_FFF0);
		write_reg(REG_PAPER_COLOR, 32'hFFFF_FFFF);
		write_reg(REG_CURSOR_SHOWN, 32'hFFFF_FFFE);
		send_item(make_item(KIND_SET, 8'h00, 5'd0, 7'd0));
		send_item(make_item(KIND_PUT, 8'h5A, 5'd0, 7'd0));
		send_item(make_item(KIND_READ, 8'h00, 5'd24, 7'd79));
		wait_idle();
		write_reg(REG_CURSOR_SHOWN, 32'h1);
		send_item(make_item(KIND_SET, 8'h00, 5'd31, 7'd127));
		send_item(make_item(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0));
	endtask

	task automatic test_random_traffic();
		idle_pct = $urandom_range(0, 30);
		stall_pct = $urandom_range(0, 10);
		set_frame(0, 0, 25, 80, 4'($urandom), 4'($urandom), 1'b1);
		run_traffic(150, 2);
		idle_pct = $urandom_range(0, 30);
		set_frame(3, 5, 4, 10, 4'($urandom), 4'($urandom), 1'b1);
		run_traffic(400, 15);
		stall_pct = $urandom_range(0, 10);
		set_frame($urandom_range(0, 24), $urandom_range(0, 79), 1, 1, 4'h0, 4'hF, 1'b1);
		run_traffic(200, 10);
		set_frame(22, 72, 6, 12, 4'hF, 4'h0, 1'b1);
		run_traffic(400, 10);
		idle_pct = $urandom_range(0, 30);
		set_frame($urandom_range(0, 24), $urandom_range(0, 79), $urandom_range(1, 8),
			$urandom_range(1, 20), 4'($urandom), 4'($urandom), 1'b0);
		run_traffic(250, 10);
		set_frame(0, 0, 0, 0, 4'($urandom), 4'($urandom), 1'b1);
		run_traffic(150, 10);
		// Largest frame at the far corner: keep newlines rare, each scroll is long.
		set_frame(24, 79, 25, 80, 4'($urandom), 4'($urandom), 1'b1);
		run_traffic(100, 1);
	endtask

	task automatic test_back_to_back();
		idle_pct = 0;
		stall_pct = 0;
		set_frame($urandom_range(0, 20), $urandom_range(0, 70), $urandom_range(1, 6),
			$urandom_range(1, 16), 4'($urandom), 4'($urandom), 1'b1);
		run_traffic(150, 10);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_store();
		test_control_chars();
		test_frame_edges();
		test_random_traffic();
		test_back_to_back();
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
